[design/anagram_window_match_counter_unit_macros.svh]
// Assertion macros for the anagram window match counter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ANAGRAM_WINDOW_MATCH_COUNTER_UNIT_MACROS_SVH
`define ANAGRAM_WINDOW_MATCH_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AWMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AWMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/awmc_pkg.sv]
// Shared constants, types and helpers for the anagram window match counter.
// No dependencies; used by every module of the block.
`default_nettype none

package awmc_pkg;

    localparam int MAX_PATTERNS = 1024;
    localparam int WINDOW_LEN   = 8;
    localparam int PAT_LETTERS  = 8;
    localparam int LETTER_W     = 5;
    localparam int SIG_W        = PAT_LETTERS * LETTER_W;
    localparam int ADDR_W       = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CNT_W        = $clog2(MAX_PATTERNS + 1);
    localparam int FILL_W       = $clog2(WINDOW_LEN + 1);
    localparam int PASS_W       = $clog2(WINDOW_LEN);
    localparam int OUT_CNT_W    = 11;
    localparam int TOTAL_W      = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_PATTERNS);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(WINDOW_LEN - 1);

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_TEXT    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef logic [WINDOW_LEN-1:0][LETTER_W-1:0] letters_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [SIG_W-1:0]  data;
    } tbl_wr_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] hit_cnt;
    } scan_stat_t;

    function automatic logic [SIG_W-1:0] pack_sig(input letters_t a);
        logic [SIG_W-1:0] s;
        s = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            s[LETTER_W*i +: LETTER_W] = a[i];
        end
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] addr_to_cnt(input logic [ADDR_W-1:0] a);
        return CNT_W'(a);
    endfunction

    function automatic logic [OUT_CNT_W-1:0] fit_cnt(input logic [CNT_W-1:0] v);
        return OUT_CNT_W'(v);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
                                                  input logic [CNT_W-1:0] m);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + (TOTAL_W + 1)'(m);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/awmc_sorter.sv]
// Iterative letter sorter: one odd-even transposition pass per cycle.
// Depends on awmc_pkg.
`default_nettype none

module awmc_sorter (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire awmc_pkg::letters_t        din,
    output logic                           done,
    output logic [awmc_pkg::SIG_W-1:0]     sig
);

    awmc_pkg::letters_t              arr_reg;
    awmc_pkg::letters_t              arr_next;
    logic [awmc_pkg::PASS_W-1:0]     pass_reg;
    logic                            busy_reg;
    logic                            done_reg;

    // Compare-exchange on disjoint adjacent pairs; phase picks even or odd pairs.
    always_comb
    begin
        arr_next = arr_reg;
        for (int i = 0; i < awmc_pkg::WINDOW_LEN - 1; i++)
        begin
            if ((((i % 2) == 1) == pass_reg[0]) && (arr_reg[i] > arr_reg[i+1]))
            begin
                arr_next[i]   = arr_reg[i+1];
                arr_next[i+1] = arr_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            arr_reg <= din;
        end
        else if (busy_reg)
        begin
            arr_reg <= arr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pass_reg <= '0;
        end
        else
        begin
            // Pulse done for one cycle after the last pass.
            done_reg <= !start && busy_reg && (pass_reg == awmc_pkg::LAST_PASS);
            if (start)
            begin
                busy_reg <= 1'b1;
                pass_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (pass_reg == awmc_pkg::LAST_PASS)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pass_reg <= pass_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign sig  = awmc_pkg::pack_sig(arr_reg);

endmodule

`default_nettype wire

[design/awmc_table.sv]
// Pattern signature table with a one-entry-per-cycle match scanner.
// Depends on awmc_pkg.
`default_nettype none

module awmc_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire awmc_pkg::tbl_wr_t         wr,
    input  wire logic                      scan_start,
    input  wire logic [awmc_pkg::SIG_W-1:0] scan_key,
    input  wire logic [awmc_pkg::CNT_W-1:0] scan_count,
    output awmc_pkg::scan_stat_t           stat
);

    logic [awmc_pkg::SIG_W-1:0]  mem [0:awmc_pkg::MAX_PATTERNS-1];
    logic [awmc_pkg::SIG_W-1:0]  rdata_reg;
    logic [awmc_pkg::SIG_W-1:0]  key_reg;
    logic [awmc_pkg::CNT_W-1:0]  last_reg;
    logic [awmc_pkg::ADDR_W-1:0] rd_addr_reg;
    logic [awmc_pkg::CNT_W-1:0]  matches_reg;
    logic                        busy_reg;
    logic                        issue_reg;
    logic                        rvalid_reg;
    logic                        done;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            key_reg  <= scan_key;
            last_reg <= scan_count - 1'b1;
        end
    end

    assign done = busy_reg && !issue_reg && !rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            issue_reg   <= 1'b0;
            rvalid_reg  <= 1'b0;
            rd_addr_reg <= '0;
            matches_reg <= '0;
        end
        else if (scan_start)
        begin
            busy_reg    <= 1'b1;
            issue_reg   <= (scan_count != '0);
            rvalid_reg  <= 1'b0;
            rd_addr_reg <= '0;
            matches_reg <= '0;
        end
        else if (busy_reg)
        begin
            rvalid_reg <= issue_reg;
            if (issue_reg)
            begin
                // Stop issuing after the last stored entry.
                if (awmc_pkg::addr_to_cnt(rd_addr_reg) == last_reg)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end
            if (rvalid_reg && (rdata_reg == key_reg))
            begin
                matches_reg <= matches_reg + 1'b1;
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.done    = done;
    assign stat.hit_cnt = matches_reg;

endmodule

`default_nettype wire

[design/anagram_window_match_counter_unit.sv]
// Top level of the anagram window match counter: sequencer, text window, totals.
// Depends on awmc_pkg, awmc_sorter, awmc_table and the assertion macro header.
//
// Usage:
//   Input words arrive on s_axis; tuser carries the mode (load pattern, text
//   letter, restart text, clear table), tdata the pattern letters and letter.
//   Every input word yields exactly one output word on m_axis with the window
//   status, the matches of this letter, the running total, the table fill
//   and the load-rejected flag.
//   Path from acceptance to the result word:
//     restart, clear, rejected load, text letter with window not yet full: straight to the result
//     pattern load: sort (one sort pass per cycle), then table write, then result
//     text letter with full window: sort, then a scan of every loaded pattern, then result;
//       the scan reads one stored signature per cycle through its one port.
//   One word is in flight at a time; s_axis_tready is high only when idle, so
//   a new word is not accepted until the result of the last one is taken.
//   A stalled receiver holds the result in the output register; nothing moves
//   until m_axis_tready takes it.
//   Reset empties the table count, the window, the fill count and the total;
//   the signature memory itself is not cleared and needs no clearing pass.
`default_nettype none

module anagram_window_match_counter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [39:0] pattern_letters, [44:40] letter, [47:45] zero
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] window_full, [11:1] matches_now, [43:12] total_matches,
    // [54:44] patterns_loaded, [55] load_rejected
    output logic [55:0]      m_axis_tdata
);

`include "anagram_window_match_counter_unit_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SORT = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                              state_reg;
    logic                                load_op_reg;
    awmc_pkg::letters_t                  win_reg;
    awmc_pkg::letters_t                  win_shift;
    awmc_pkg::letters_t                  pat_letters;
    awmc_pkg::letters_t                  sort_din;
    logic [awmc_pkg::FILL_W-1:0]         fill_reg;
    logic [awmc_pkg::FILL_W-1:0]         fill_next;
    logic [awmc_pkg::TOTAL_W-1:0]        total_reg;
    logic [awmc_pkg::CNT_W-1:0]          count_reg;
    logic [awmc_pkg::CNT_W-1:0]          matches_reg;
    logic                                rejected_reg;

    logic                                accept;
    logic                                is_load;
    logic                                is_text;
    logic                                is_restart;
    logic                                table_full;
    logic                                sort_start;
    logic                                sort_done;
    logic [awmc_pkg::SIG_W-1:0]          sort_sig;
    logic                                scan_start;
    awmc_pkg::tbl_wr_t                   tbl_wr;
    awmc_pkg::scan_stat_t                scan_stat;
    logic [awmc_pkg::LETTER_W-1:0]       in_letter;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = (s_axis_tuser == awmc_pkg::MODE_LOAD);
    assign is_text       = (s_axis_tuser == awmc_pkg::MODE_TEXT);
    assign is_restart    = (s_axis_tuser == awmc_pkg::MODE_RESTART);
    assign table_full    = (count_reg >= awmc_pkg::CNT_MAX);
    assign in_letter     = s_axis_tdata[awmc_pkg::SIG_W +: awmc_pkg::LETTER_W];

    // Shift the window (the newest letter enters the last slot) and unpack the pattern letters.
    always_comb
    begin
        for (int i = 0; i < awmc_pkg::WINDOW_LEN - 1; i++)
        begin
            win_shift[i] = win_reg[i+1];
        end
        win_shift[awmc_pkg::WINDOW_LEN-1] = in_letter;
        for (int i = 0; i < awmc_pkg::WINDOW_LEN; i++)
        begin
            pat_letters[i] = s_axis_tdata[awmc_pkg::LETTER_W*i +: awmc_pkg::LETTER_W];
        end
    end

    assign fill_next = (fill_reg < awmc_pkg::FILL_FULL) ? fill_reg + 1'b1 : fill_reg;
    assign sort_din  = is_load ? pat_letters : win_shift;
    assign sort_start = accept && ((is_load && !table_full) ||
                                   (is_text && (fill_next == awmc_pkg::FILL_FULL)));

    // Sort finished: a load writes the table, a text letter starts the scan.
    assign scan_start   = (state_reg == ST_SORT) && sort_done && !load_op_reg;
    assign tbl_wr.we    = (state_reg == ST_SORT) && sort_done && load_op_reg;
    assign tbl_wr.addr  = count_reg[awmc_pkg::ADDR_W-1:0];
    assign tbl_wr.data  = sort_sig;

    awmc_sorter u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .din   (sort_din),
        .done  (sort_done),
        .sig   (sort_sig)
    );

    awmc_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (tbl_wr),
        .scan_start (scan_start),
        .scan_key   (sort_sig),
        .scan_count (count_reg),
        .stat       (scan_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_op_reg  <= 1'b0;
            win_reg      <= '0;
            fill_reg     <= '0;
            total_reg    <= '0;
            count_reg    <= '0;
            matches_reg  <= '0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        matches_reg  <= '0;
                        load_op_reg  <= is_load;
                        state_reg    <= sort_start ? ST_SORT : ST_OUT;
                        unique case (s_axis_tuser)
                            awmc_pkg::MODE_LOAD:
                            begin
                                rejected_reg <= table_full;
                            end
                            awmc_pkg::MODE_TEXT:
                            begin
                                rejected_reg <= 1'b0;
                                win_reg      <= win_shift;
                                fill_reg     <= fill_next;
                            end
                            awmc_pkg::MODE_RESTART:
                            begin
                                rejected_reg <= 1'b0;
                                win_reg      <= '0;
                                fill_reg     <= '0;
                                total_reg    <= '0;
                            end
                            awmc_pkg::MODE_CLEAR:
                            begin
                                rejected_reg <= 1'b0;
                                count_reg    <= '0;
                            end
                            default:
                            begin
                                rejected_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SORT:
                begin
                    if (sort_done)
                    begin
                        if (load_op_reg)
                        begin
                            count_reg <= count_reg + 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_stat.done)
                    begin
                        matches_reg <= scan_stat.hit_cnt;
                        total_reg   <= awmc_pkg::sat_add(total_reg, scan_stat.hit_cnt);
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result fields are read straight from the registers, which hold in ST_OUT.
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {rejected_reg,
                            awmc_pkg::fit_cnt(count_reg),
                            total_reg,
                            awmc_pkg::fit_cnt(matches_reg),
                            (fill_reg == awmc_pkg::FILL_FULL)};

    `AWMC_ASSERT_NOW(a_idle_no_result, state_reg == ST_IDLE, !m_axis_tvalid,
        "result valid while idle")
    `AWMC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= awmc_pkg::CNT_MAX,
        "pattern count above table depth")
    `AWMC_ASSERT_NEXT(a_full_load_rejected, accept && is_load && table_full,
        rejected_reg && (state_reg == ST_OUT), "full-table load not rejected")
    `AWMC_ASSERT_NOW(a_matches_bound, state_reg == ST_OUT, matches_reg <= count_reg,
        "more matches than stored patterns")
    `AWMC_ASSERT_NEXT(a_restart_clears, accept && is_restart,
        (total_reg == '0) && (fill_reg == '0), "restart left text state")

endmodule

`default_nettype wire
